[hdl/mm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

  // matrix geometry
  localparam int MAX_DIM = 8;
  localparam int DIM_W   = 3;
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int CFG_W   = 4;

  // element and accumulator formats
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + DIM_W;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  // input function codes
  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_START
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]              func;
    logic [DIM_W-1:0]        row;
    logic [DIM_W-1:0]        col;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]        out_row;
    logic [DIM_W-1:0]        out_col;
    logic signed [DATA_W-1:0] sum;
    logic                    saturated;
    logic                    last;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    cmd_kind_t               kind;
    logic [ADDR_W-1:0]       addr;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  // last loop index of each dimension, already clamped
  typedef struct packed {
    logic [DIM_W-1:0] m_last;
    logic [DIM_W-1:0] n_last;
    logic [DIM_W-1:0] q_last;
  } dims_t;

  // register value to last index: zero counts as one, above max counts as max
  function automatic logic [DIM_W-1:0] clamp_last(input logic [CFG_W-1:0] d);
    logic [CFG_W-1:0] dm1;
    dm1 = d - 4'd1;
    if (d == '0) begin
      return '0;
    end else if (d > CFG_W'(MAX_DIM)) begin
      return DIM_W'(MAX_DIM - 1);
    end else begin
      return dm1[DIM_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

[hdl/mm_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module mm_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mm_pkg::in_item_t in_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output mm_pkg::cmd_t          q_data
);
  import mm_pkg::*;

  logic  fr_v_r;
  logic  fr_v_nxt;
  cmd_t  fr_cmd_r;
  cmd_t  fr_cmd_nxt;
  logic  in_beat;
  logic  keep;

  // hand the held command to the queue when it has room
  assign q_push   = fr_v_r && !q_full;
  assign q_data   = fr_cmd_r;
  assign in_ready = !fr_v_r || !q_full;
  assign in_beat  = in_valid && in_ready;

  // classify the beat; unused codes and out-of-range loads are dropped
  always_comb begin
    keep       = 1'b0;
    fr_cmd_nxt = fr_cmd_r;
    case (in_data.func)
      FUNC_LOAD_A, FUNC_LOAD_B: begin
        keep = ({1'b0, in_data.row} < (DIM_W+1)'(MAX_DIM)) &&
               ({1'b0, in_data.col} < (DIM_W+1)'(MAX_DIM));
        fr_cmd_nxt.kind = (in_data.func == FUNC_LOAD_A) ? CMD_LOAD_A : CMD_LOAD_B;
      end
      FUNC_START: begin
        keep            = 1'b1;
        fr_cmd_nxt.kind = CMD_START;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
    fr_cmd_nxt.addr  = {in_data.row, in_data.col};
    fr_cmd_nxt.value = in_data.value;
    if (in_beat) begin
      fr_v_nxt = keep;
    end else if (q_push) begin
      fr_v_nxt = 1'b0;
    end else begin
      fr_v_nxt = fr_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  // payload holding register
  always_ff @(posedge clk) begin
    if (in_beat) begin
      fr_cmd_r <= fr_cmd_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/mm_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module mm_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire mm_pkg::cmd_t push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              pop_valid,
  output mm_pkg::cmd_t      pop_data
);
  import mm_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // occupancy checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

[hdl/mm_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module mm_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  input  wire mm_pkg::cmd_t      q_data,
  output logic                   q_pop,
  input  wire mm_pkg::dims_t     dims,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mm_pkg::out_item_t      out_data
);
  import mm_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  localparam int HI_LSB = FRAC_W + DATA_W - 1;

  // sequencer state
  state_t           state_r,    state_nxt;
  logic [DIM_W-1:0] i_r,        i_nxt;
  logic [DIM_W-1:0] j_r,        j_nxt;
  logic [DIM_W-1:0] p_r,        p_nxt;
  logic             issuing_r,  issuing_nxt;
  logic             busy_r,     busy_nxt;
  logic [DIM_W-1:0] el_row_r,   el_row_nxt;
  logic [DIM_W-1:0] el_col_r,   el_col_nxt;
  logic             el_last_r,  el_last_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic             issue;
  logic             issue_last;
  logic             wr_a;
  logic             wr_b;

  // element stores and datapath
  logic signed [DATA_W-1:0] mem_a [MAX_DIM*MAX_DIM];
  logic signed [DATA_W-1:0] mem_b [MAX_DIM*MAX_DIM];
  logic signed [DATA_W-1:0] a_q_r;
  logic signed [DATA_W-1:0] b_q_r;
  logic                     s1_v_r, s1_first_r, s1_last_r;
  logic                     s2_v_r, s2_first_r, s2_last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic                     done_r;
  logic [ACC_W-HI_LSB-1:0]  acc_hi;
  logic                     sat;

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign issue_last = (p_r == dims.n_last);

  // saturate the floored sum to the element range
  assign acc_hi = acc_r[ACC_W-1:HI_LSB];
  assign sat    = !((&acc_hi) || !(|acc_hi));

  // command dispatch, loop counters and result register
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    issuing_nxt   = issuing_r;
    busy_nxt      = busy_r;
    el_row_nxt    = el_row_r;
    el_col_nxt    = el_col_r;
    el_last_nxt   = el_last_r;
    q_pop         = 1'b0;
    issue         = 1'b0;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (done_r) begin
      busy_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_data.kind)
            CMD_LOAD_A: wr_a = 1'b1;
            CMD_LOAD_B: wr_b = 1'b1;
            CMD_START: begin
              state_nxt   = S_RUN;
              i_nxt       = '0;
              j_nxt       = '0;
              p_nxt       = '0;
              issuing_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (issuing_r) begin
          issue = 1'b1;
          if (issue_last) begin
            issuing_nxt = 1'b0;
            p_nxt       = '0;
            el_row_nxt  = i_r;
            el_col_nxt  = j_r;
            el_last_nxt = (i_r == dims.m_last) && (j_r == dims.q_last);
            if (j_r == dims.q_last) begin
              j_nxt = '0;
              if (i_r == dims.m_last) begin
                state_nxt = S_IDLE;
              end else begin
                i_nxt = i_r + 1'b1;
              end
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end else begin
            p_nxt = p_r + 1'b1;
          end
        end else if (!busy_r && !out_valid_r) begin
          // next element starts once the result slot is free
          issuing_nxt = 1'b1;
          busy_nxt    = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // result register
    if (done_r) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.out_row   = el_row_r;
      out_data_nxt.out_col   = el_col_r;
      out_data_nxt.saturated = sat;
      out_data_nxt.last      = el_last_r;
      if (sat) begin
        out_data_nxt.sum = acc_r[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                          : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
        out_data_nxt.sum = acc_r[HI_LSB:FRAC_W];
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      p_r         <= '0;
      issuing_r   <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      p_r         <= p_nxt;
      issuing_r   <= issuing_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
    el_row_r   <= el_row_nxt;
    el_col_r   <= el_col_nxt;
    el_last_r  <= el_last_nxt;
    out_data_r <= out_data_nxt;
  end

  // element stores, registered read
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[q_data.addr] <= q_data.value;
    end
    a_q_r <= mem_a[{i_r, p_r}];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[q_data.addr] <= q_data.value;
    end
    b_q_r <= mem_b[{p_r, j_r}];
  end

  // multiply-accumulate pipeline
  assign acc_nxt = (s2_first_r ? {ACC_W{1'b0}} : acc_r) +
                   {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      done_r <= s2_v_r && s2_last_r;
    end
    s1_first_r <= (p_r == '0);
    s1_last_r  <= issue_last;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    prod_r     <= a_q_r * b_q_r;
    if (s2_v_r) begin
      acc_r <= acc_nxt;
    end
  end

  // a finished sum never lands on an unsent result
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !out_valid_r)
    else $error("result overwrites a waiting beat");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> busy_r)
    else $error("sum finished with no element in flight");

  a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> out_valid_r)
    else $error("finished sum not presented");

  a_no_load_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_a || wr_b) |-> !issuing_r)
    else $error("store written while reads in progress");

endmodule

`default_nettype wire

[hdl/matrix_multiply_core.sv]
// matrix_multiply_core: C = A x B over signed Q16.16 elements, up to 8 x 8.
// Input channel (in_valid/in_ready/in_data): func 0 writes A[row][col], func 1
// writes B[row][col], func 2 starts the multiply, func 3 is dropped. Load beats
// are taken one per cycle while the command queue has room, and give no result.
// A start beat yields rows_a * cols_b result beats on out_* in row-major
// order; the final one has last set. Each sum is floored to Q16.16 and
// clipped to the 32-bit range, with saturated flagging a clip.
// Elements are computed in turn by the single multiply-accumulate pipeline
// (store read, multiply, accumulate, result register); each starts once the
// previous sum is done and the result slot is free. Beats after a start wait
// in a small command queue; loads behind it are applied once its last element
// has been read. Dimensions are set over the APB port (rows_a at 0x0,
// inner_dim at 0x4, cols_b at 0x8); 0 counts as 1, above 8 as 8. The user must
// write them only while the block is idle; the block does not enforce this.
// Reset sets all three dimensions to 8 and empties the queue and pipeline;
// the element stores keep no reset value and must be loaded before use.
// A stalled receiver holds the result beat and the next element waits.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input items
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mm_pkg::in_item_t  in_data,
  // result items
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mm_pkg::out_item_t      out_data,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import mm_pkg::*;

  logic [CFG_W-1:0] rows_a_r;
  logic [CFG_W-1:0] inner_dim_r;
  logic [CFG_W-1:0] cols_b_r;
  logic             cfg_wr;
  dims_t            dims;
  logic             q_push;
  cmd_t             q_push_data;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  cmd_t             q_pop_data;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= CFG_W'(MAX_DIM);
      inner_dim_r <= CFG_W'(MAX_DIM);
      cols_b_r    <= CFG_W'(MAX_DIM);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROWS_A:    rows_a_r    <= pwdata[CFG_W-1:0];
        REG_INNER_DIM: inner_dim_r <= pwdata[CFG_W-1:0];
        REG_COLS_B:    cols_b_r    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS_A:    prdata = {28'd0, rows_a_r};
      REG_INNER_DIM: prdata = {28'd0, inner_dim_r};
      REG_COLS_B:    prdata = {28'd0, cols_b_r};
      default:       prdata = '0;
    endcase
  end

  // clamped loop bounds
  assign dims.m_last = clamp_last(rows_a_r);
  assign dims.n_last = clamp_last(inner_dim_r);
  assign dims.q_last = clamp_last(cols_b_r);

  mm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  mm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_pop_data)
  );

  mm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .dims      (dims),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[verif/tb_matrix_multiply_core.sv]
`timescale 1ns / 1ps

module tb_matrix_multiply_core;
  import mm_pkg::*;

  // func code with no meaning, and a register index with no register
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;

  localparam int RANDOM_TARGET = 140;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  // worst case: every beat a full 8x8 start with a receiver stall on each
  // element, then taken a few times over
  localparam int CYCLE_LIMIT   = 10_000_000;

  localparam logic signed [71:0] Q_MAX = 72'sd2147483647;
  localparam logic signed [71:0] Q_MIN = -72'sd2147483648;

  // expectation pinned to one input beat by hand
  typedef struct packed {
    logic        typed;
    logic [31:0] sum;
    logic        sat;
  } pin_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        typed;
    logic [31:0] sum;
    logic        sat;
  } dir_row_t;

  // directed beats, all run with 1 x 1 x 1 dimensions
  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // largest times largest clips high
    '{FUNC_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 32'h0, 1'b0},
    '{FUNC_LOAD_B, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 32'h0, 1'b0},
    '{FUNC_START,  3'd0, 3'd0, 32'h0,         1'b1, 32'h7fff_ffff, 1'b1},
    // most negative times largest clips low
    '{FUNC_LOAD_A, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{FUNC_START,  3'd0, 3'd0, 32'h0,         1'b1, 32'h8000_0000, 1'b1},
    // most negative squared clips high
    '{FUNC_LOAD_B, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{FUNC_START,  3'd0, 3'd0, 32'h0,         1'b1, 32'h7fff_ffff, 1'b1},
    // one times minus one half
    '{FUNC_LOAD_A, 3'd0, 3'd0, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{FUNC_LOAD_B, 3'd0, 3'd0, 32'hffff_8000, 1'b0, 32'h0, 1'b0},
    '{FUNC_START,  3'd0, 3'd0, 32'h0,         1'b1, 32'hffff_8000, 1'b0},
    // tiny negative product floors to minus one lsb
    '{FUNC_LOAD_A, 3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
    '{FUNC_LOAD_B, 3'd0, 3'd0, 32'hffff_ffff, 1'b0, 32'h0, 1'b0},
    '{FUNC_START,  3'd0, 3'd0, 32'h0,         1'b1, 32'hffff_ffff, 1'b0},
    // tiny positive product floors to zero
    '{FUNC_LOAD_B, 3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
    '{FUNC_START,  3'd0, 3'd0, 32'h0,         1'b1, 32'h0, 1'b0},
    // element outside the dimensions and an unused code change nothing
    '{FUNC_LOAD_A, 3'd0, 3'd1, 32'h7fff_ffff, 1'b0, 32'h0, 1'b0},
    '{FUNC_UNUSED, 3'd0, 3'd0, 32'h1234_5678, 1'b0, 32'h0, 1'b0},
    '{FUNC_START,  3'd0, 3'd0, 32'h0,         1'b1, 32'h0, 1'b0},
    // top corner of both stores
    '{FUNC_LOAD_A, 3'd7, 3'd7, 32'hdead_beef, 1'b0, 32'h0, 1'b0},
    '{FUNC_LOAD_B, 3'd7, 3'd7, 32'h55aa_55aa, 1'b0, 32'h0, 1'b0},
    '{FUNC_UNUSED, 3'd7, 3'd7, 32'hffff_ffff, 1'b0, 32'h0, 1'b0},
    // zero times largest
    '{FUNC_LOAD_A, 3'd0, 3'd0, 32'h0,         1'b0, 32'h0, 1'b0},
    '{FUNC_LOAD_B, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 32'h0, 1'b0},
    '{FUNC_START,  3'd7, 3'd7, 32'hffff_ffff, 1'b1, 32'h0, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the block: element stores and dimension registers
  logic signed [31:0] a_elem [0:63];
  logic signed [31:0] b_elem [0:63];
  logic [3:0]         dim_cfg [0:2] = '{4'd8, 4'd8, 4'd8};

  out_item_t c_elem_q [$];
  pin_t      pin_q [$];

  int mismatches = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit hold_armed = 1'b0;

  matrix_multiply_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // element values: mostly moderate so sums stay in range, some extremes
  function automatic logic [31:0] rand_elem();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
    if (r < 60) return $urandom_range(0, 1) ? 32'($urandom_range(0, 255))
                                            : -32'($urandom_range(0, 255));
    if (r < 80) return $urandom;
    if (r < 88) return 32'h7fff_ffff;
    if (r < 94) return 32'h8000_0000;
    if (r < 97) return 32'h0;
    return 32'h0001_0000;
  endfunction

  function automatic logic [3:0] pick_dim();
    if ($urandom_range(0, 3) != 0) return 4'($urandom_range(1, 4));
    return 4'($urandom_range(0, 15));
  endfunction

  // register value as the block uses it
  function automatic int eff_dim(input logic [3:0] d);
    if (d == 4'd0) return 1;
    if (d > 4'(MAX_DIM)) return MAX_DIM;
    return int'(d);
  endfunction

  // update the stores, or queue every element of C for a start beat
  task automatic gemm_apply_beat(input in_item_t beat, input pin_t pin);
    int m;
    int n;
    int q;
    logic signed [71:0] acc;
    logic signed [71:0] pa;
    logic signed [71:0] pb;
    out_item_t c;
    case (beat.func)
      FUNC_LOAD_A: a_elem[{beat.row, beat.col}] = beat.value;
      FUNC_LOAD_B: b_elem[{beat.row, beat.col}] = beat.value;
      FUNC_START: begin
        m = eff_dim(dim_cfg[REG_ROWS_A]);
        n = eff_dim(dim_cfg[REG_INNER_DIM]);
        q = eff_dim(dim_cfg[REG_COLS_B]);
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < q; j++) begin
            acc = '0;
            for (int p = 0; p < n; p++) begin
              pa = a_elem[i * MAX_DIM + p];
              pb = b_elem[p * MAX_DIM + j];
              acc = acc + pa * pb;
            end
            // floor to q16.16, then clip
            acc = acc >>> FRAC_W;
            c.saturated = 1'b0;
            if (acc > Q_MAX) begin
              acc = Q_MAX;
              c.saturated = 1'b1;
            end else if (acc < Q_MIN) begin
              acc = Q_MIN;
              c.saturated = 1'b1;
            end
            c.sum = acc[31:0];
            c.out_row = 3'(i);
            c.out_col = 3'(j);
            c.last = (i == m - 1) && (j == q - 1);
            if (pin.typed) begin
              c.sum = pin.sum;
              c.saturated = pin.sat;
            end
            c_elem_q.push_back(c);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want, input out_item_t exp_c);
    if (got !== want) begin
      report_mismatch($sformatf("C[%0d][%0d] %s: got %h, expected %h",
                                exp_c.out_row, exp_c.out_col, name, got, want));
    end
  endtask

  task automatic check_c_elem(input out_item_t got);
    out_item_t want;
    if (c_elem_q.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing pending: row %0d col %0d sum %h",
                                got.out_row, got.out_col, got.sum));
    end else begin
      want = c_elem_q.pop_front();
      compare_field("out_row", 32'(got.out_row), 32'(want.out_row), want);
      compare_field("out_col", 32'(got.out_col), 32'(want.out_col), want);
      compare_field("sum", got.sum, want.sum, want);
      compare_field("saturated", 32'(got.saturated), 32'(want.saturated), want);
      compare_field("last", 32'(got.last), 32'(want.last), want);
    end
  endtask

  // result beats are checked before the input beat of the same edge is applied
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_c_elem(out_data);
      if (in_valid && in_ready) gemm_apply_beat(in_data, pin_q.pop_front());
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result receiver: random stalls, free-running stretches, one long hold
  initial begin : result_sink
    int hold_left;
    int stall_left;
    int run_left;
    hold_left = 0;
    stall_left = 0;
    run_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && out_valid) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else if ($urandom_range(0, 9) == 0) begin
          run_left = $urandom_range(30, 80);
        end else begin
          run_left = $urandom_range(0, 5);
          stall_left = pick_gap();
        end
      end
    end
  end

  // apb write: setup cycle, access cycle
  task automatic cfg_write(input logic [1:0] idx, input logic [3:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {$urandom_range(0, 1) ? 28'($urandom) : 28'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx <= REG_COLS_B) dim_cfg[idx] = val;
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [1:0] idx, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // read back all three dimension registers
  task automatic check_dims();
    logic [31:0] got;
    for (int i = REG_ROWS_A; i <= REG_COLS_B; i++) begin
      cfg_read(2'(i), got);
      if (got !== 32'(dim_cfg[i])) begin
        report_mismatch($sformatf("register %0d reads %h, expected %h",
                                  i, got, 32'(dim_cfg[i])));
      end
    end
  endtask

  // offer one input beat and wait for it to be taken
  task automatic send_beat(input in_item_t beat, input pin_t pin);
    int gap;
    gap = (burst_left > 0) ? 0 : pick_gap();
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    pin_q.push_back(pin);
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering, let every pending element out, then let trailing loads land
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (c_elem_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    in_item_t beat;
    pin_t pin;
    int random_items;
    int phase;
    int n;
    int r;
    bit pressure;
    logic [3:0] dr;
    logic [3:0] di;
    logic [3:0] dc;

    random_items = 0;
    phase = 0;
    pin = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dimensions after reset, then zero counts as one
    check_dims();
    cfg_write(REG_ROWS_A, 4'd0);
    cfg_write(REG_INNER_DIM, 4'd1);
    cfg_write(REG_COLS_B, 4'd0);
    cfg_write(REG_UNUSED, 4'd7);
    check_dims();

    // directed table
    for (int k = 0; k < DIR_ROWS; k++) begin
      beat.func = DIR_TAB[k].func;
      beat.row = DIR_TAB[k].row;
      beat.col = DIR_TAB[k].col;
      beat.value = DIR_TAB[k].value;
      pin.typed = DIR_TAB[k].typed;
      pin.sum = DIR_TAB[k].sum;
      pin.sat = DIR_TAB[k].sat;
      send_beat(beat, pin);
    end
    wait_idle();

    // fill both stores so no start reads an unwritten element
    pin = '0;
    for (int k = 0; k < 2 * MAX_DIM * MAX_DIM; k++) begin
      beat.func = (k % 2 == 0) ? FUNC_LOAD_A : FUNC_LOAD_B;
      {beat.row, beat.col} = 6'(k / 2);
      beat.value = rand_elem();
      send_beat(beat, pin);
    end
    wait_idle();

    // random phases, each under its own dimensions
    while (random_items < RANDOM_TARGET) begin
      case (phase)
        0: begin dr = 4'd15; di = 4'd15; dc = 4'd15; end
        1: begin dr = 4'd2; di = 4'd3; dc = 4'd2; end
        2: begin dr = 4'd1; di = 4'd8; dc = 4'd1; end
        3: begin dr = 4'd8; di = 4'd1; dc = 4'd8; end
        4: begin dr = 4'd0; di = 4'd9; dc = 4'd0; end
        default: begin dr = pick_dim(); di = pick_dim(); dc = pick_dim(); end
      endcase
      cfg_write(REG_ROWS_A, dr);
      cfg_write(REG_INNER_DIM, di);
      cfg_write(REG_COLS_B, dc);
      if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, 4'($urandom));
      check_dims();

      // one phase holds the receiver off while beats keep coming
      pressure = (phase == 1);
      hold_armed = pressure;
      burst_left = (pressure || $urandom_range(0, 2) == 0) ? 40 : 0;
      n = (phase == 0) ? 4 : $urandom_range(6, 16);
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if ((pressure && k == 0) || k == n - 1 || r < 12) beat.func = FUNC_START;
        else if (r < 18) beat.func = FUNC_UNUSED;
        else if (r < 59) beat.func = FUNC_LOAD_A;
        else beat.func = FUNC_LOAD_B;
        beat.row = 3'($urandom_range(0, 7));
        beat.col = 3'($urandom_range(0, 7));
        beat.value = rand_elem();
        send_beat(beat, pin);
        if (beat.func != FUNC_UNUSED) random_items++;
      end
      wait_idle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mm_pkg.sv
hdl/mm_front.sv
hdl/mm_queue.sv
hdl/mm_back.sv
hdl/matrix_multiply_core.sv
verif/tb_matrix_multiply_core.sv
